// File: src/pwlc_pkg.sv
// ============================================================================
// pwlc_pkg
// Shared types and constants for the piecewise-linear curve evaluator.
// ============================================================================
package pwlc_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int LEVEL_W    = 16;
    localparam int VALUE_W    = 32;
    localparam int SLOT_W     = 4;
    localparam int CFG_W      = 5;

    // Stream payload widths
    localparam int IN_FIELDS_W = SLOT_W + LEVEL_W + VALUE_W + LEVEL_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = VALUE_W;
    localparam int IN_USER_W   = 1;
    localparam int OUT_USER_W  = 2;

    // Interpolation arithmetic
    localparam int DIFF_W    = VALUE_W + 1;
    localparam int DQ_W      = LEVEL_W + 1;
    localparam int PROD_W    = DIFF_W + DQ_W;
    localparam int DIV_W     = PROD_W - 2;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIVC_W    = $clog2(DIV_STEPS);

    localparam logic [VALUE_W-1:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } cmd_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DIVINIT,
        ST_DIV,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0]
    {
        RSEL_ZERO,
        RSEL_LAST,
        RSEL_NEXT
    } rd_sel_t;

    typedef enum logic [2:0]
    {
        RES_NONE,
        RES_DEFAULT,
        RES_CLAMP,
        RES_PREV,
        RES_LAST,
        RES_INTERP
    } res_sel_t;

    typedef struct packed
    {
        logic     mem_wr;
        logic     start;
        rd_sel_t  rd_sel;
        logic     idx_adv;
        logic     save_prev;
        logic     save_last;
        res_sel_t res_sel;
        logic     seg_load;
        logic     mul;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } ctl_cmd_t;

    typedef struct packed
    {
        logic n_zero;
        logic le_first;
        logic ge_last;
        logic seg_hit;
        logic seg_zero;
        logic at_last;
        logic div_last;
    } dp_status_t;

endpackage

// File: src/pwlc_ctrl.sv
// ============================================================================
// pwlc_ctrl
// Sequencer for table writes, end checks, segment scan and division.
// ============================================================================
module pwlc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    input  pwlc_pkg::cmd_t      s_cmd,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  pwlc_pkg::dp_status_t st,
    output pwlc_pkg::ctl_cmd_t  cmd
);
    import pwlc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RSEL_ZERO;
        cmd.res_sel = RES_NONE;
        s_ready    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    if (s_cmd == CMD_WRITE)
                    begin
                        cmd.mem_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.start = 1'b1;
                        if (st.n_zero)
                        begin
                            cmd.res_sel = RES_DEFAULT;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_FIRST;
                        end
                    end
                end
            end
            ST_FIRST:
            begin
                cmd.save_prev = 1'b1;
                cmd.rd_sel    = RSEL_LAST;
                if (st.le_first)
                begin
                    cmd.res_sel = RES_CLAMP;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                cmd.save_last = 1'b1;
                cmd.rd_sel    = RSEL_NEXT;
                if (st.ge_last)
                begin
                    cmd.res_sel = RES_CLAMP;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.idx_adv = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_sel = RSEL_NEXT;
                if (st.seg_hit)
                begin
                    if (st.seg_zero)
                    begin
                        cmd.res_sel = RES_PREV;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        cmd.seg_load = 1'b1;
                        state_next   = ST_MUL;
                    end
                end
                else if (st.at_last)
                begin
                    cmd.res_sel = RES_LAST;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    cmd.idx_adv   = 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIVINIT;
            end
            ST_DIVINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.res_sel = RES_INTERP;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

// File: src/pwlc_dpath.sv
// ============================================================================
// pwlc_dpath
// Breakpoint table, segment compare, multiplier and radix-4 floor divider.
// ============================================================================
module pwlc_dpath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [pwlc_pkg::CFG_W-1:0]             cfg_wr_data,
    input  logic [pwlc_pkg::SLOT_W-1:0]            point_index,
    input  logic signed [pwlc_pkg::LEVEL_W-1:0]    point_level,
    input  logic signed [pwlc_pkg::VALUE_W-1:0]    point_value,
    input  logic signed [pwlc_pkg::LEVEL_W-1:0]    query_level,
    input  pwlc_pkg::ctl_cmd_t                     cmd,
    output pwlc_pkg::dp_status_t                   st,
    output logic [pwlc_pkg::VALUE_W-1:0]           curve_value,
    output logic                                   used_default,
    output logic                                   clamped
);
    import pwlc_pkg::*;

    logic signed [LEVEL_W-1:0] lev_mem [MAX_POINTS];
    logic signed [VALUE_W-1:0] val_mem [MAX_POINTS];

    logic [CFG_W-1:0]          points_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [DIVC_W-1:0]         div_cnt_reg;

    logic signed [LEVEL_W-1:0] query_reg;
    logic signed [LEVEL_W-1:0] rd_lev_reg;
    logic signed [VALUE_W-1:0] rd_val_reg;
    logic signed [LEVEL_W-1:0] lo_reg;
    logic signed [VALUE_W-1:0] a_reg;
    logic signed [VALUE_W-1:0] last_val_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [DQ_W-1:0]    dq_reg;
    logic [LEVEL_W-1:0]        den_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;
    logic [DIV_W-1:0]          div_sh_reg;
    logic [LEVEL_W-1:0]        rem_reg;
    logic [VALUE_W-1:0]        res_val_reg;
    logic                      res_dflt_reg;
    logic                      res_clamp_reg;
    logic [VALUE_W-1:0]        out_val_reg;
    logic                      out_dflt_reg;
    logic                      out_clamp_reg;

    logic [31:0]               slot_ext;
    logic [31:0]               n_ext;
    logic [31:0]               last_ext;
    logic [IDX_W-1:0]          last_idx;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          idx_inc;
    logic signed [DQ_W-1:0]    den_wide;
    logic [PROD_W-1:0]         nn;
    logic [LEVEL_W:0]          t1;
    logic [LEVEL_W:0]          t2;
    logic                      ge1;
    logic                      ge2;
    logic [LEVEL_W-1:0]        r1;
    logic [LEVEL_W-1:0]        r2;
    logic [DIV_W-1:0]          sh1;
    logic [DIV_W-1:0]          sh2;
    logic [DIV_W-1:0]          fq;

    // Clip the configured count to the table depth
    always_comb
    begin
        slot_ext = 32'(point_index);
        n_ext    = 32'(points_reg);
        if (n_ext > 32'(MAX_POINTS))
        begin
            n_ext = 32'(MAX_POINTS);
        end
        last_ext = n_ext - 32'd1;
        last_idx = last_ext[IDX_W-1:0];
        idx_inc  = idx_reg + IDX_W'(1);
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RSEL_ZERO: rd_addr = '0;
            RSEL_LAST: rd_addr = last_idx;
            RSEL_NEXT: rd_addr = idx_inc;
            default:   rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && (slot_ext < 32'(MAX_POINTS)))
        begin
            lev_mem[slot_ext[IDX_W-1:0]] <= point_level;
            val_mem[slot_ext[IDX_W-1:0]] <= point_value;
        end
        rd_lev_reg <= lev_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    // Status for the sequencer
    assign den_wide    = DQ_W'(rd_lev_reg) - DQ_W'(lo_reg);
    assign st.n_zero   = (points_reg == '0);
    assign st.le_first = (query_reg <= rd_lev_reg);
    assign st.ge_last  = (query_reg >= rd_lev_reg);
    assign st.seg_hit  = (query_reg >= lo_reg) && (query_reg <= rd_lev_reg);
    assign st.seg_zero = (rd_lev_reg == lo_reg);
    assign st.at_last  = (idx_reg == last_idx);
    assign st.div_last = (div_cnt_reg == DIVC_W'(DIV_STEPS - 1));

    // Two restoring steps per cycle
    always_comb
    begin
        t1  = {rem_reg, div_sh_reg[DIV_W-1]};
        ge1 = (t1 >= {1'b0, den_reg});
        r1  = ge1 ? LEVEL_W'(t1 - {1'b0, den_reg}) : t1[LEVEL_W-1:0];
        sh1 = {div_sh_reg[DIV_W-2:0], ge1};
        t2  = {r1, sh1[DIV_W-1]};
        ge2 = (t2 >= {1'b0, den_reg});
        r2  = ge2 ? LEVEL_W'(t2 - {1'b0, den_reg}) : t2[LEVEL_W-1:0];
        sh2 = {sh1[DIV_W-2:0], ge2};
    end

    // Negative products divide as ~num and come back as ~quotient: floor
    assign nn = prod_reg[PROD_W-1] ? ~prod_reg : prod_reg;
    assign fq = neg_reg ? ~div_sh_reg : div_sh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg  <= '0;
            idx_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                points_reg <= cfg_wr_data;
            end
            if (cmd.start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_adv)
            begin
                idx_reg <= idx_inc;
            end
            if (cmd.div_init)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            query_reg <= query_level;
        end
        if (cmd.save_prev)
        begin
            lo_reg <= rd_lev_reg;
            a_reg  <= rd_val_reg;
        end
        if (cmd.save_last)
        begin
            last_val_reg <= rd_val_reg;
        end
        if (cmd.seg_load)
        begin
            diff_reg <= DIFF_W'(rd_val_reg) - DIFF_W'(a_reg);
            dq_reg   <= DQ_W'(query_reg) - DQ_W'(lo_reg);
            den_reg  <= den_wide[LEVEL_W-1:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= diff_reg * dq_reg;
        end
        if (cmd.div_init)
        begin
            neg_reg    <= prod_reg[PROD_W-1];
            div_sh_reg <= nn[DIV_W-1:0];
            rem_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            div_sh_reg <= sh2;
            rem_reg    <= r2;
        end

        unique case (cmd.res_sel)
            RES_NONE:
            begin
            end
            RES_DEFAULT:
            begin
                res_val_reg   <= ONE_Q16;
                res_dflt_reg  <= 1'b1;
                res_clamp_reg <= 1'b0;
            end
            RES_CLAMP:
            begin
                res_val_reg   <= rd_val_reg;
                res_dflt_reg  <= 1'b0;
                res_clamp_reg <= 1'b1;
            end
            RES_PREV:
            begin
                res_val_reg   <= a_reg;
                res_dflt_reg  <= 1'b0;
                res_clamp_reg <= 1'b0;
            end
            RES_LAST:
            begin
                res_val_reg   <= last_val_reg;
                res_dflt_reg  <= 1'b0;
                res_clamp_reg <= 1'b0;
            end
            RES_INTERP:
            begin
                res_val_reg   <= a_reg + fq[VALUE_W-1:0];
                res_dflt_reg  <= 1'b0;
                res_clamp_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase

        if (cmd.out_load)
        begin
            out_val_reg   <= res_val_reg;
            out_dflt_reg  <= res_dflt_reg;
            out_clamp_reg <= res_clamp_reg;
        end
    end

    assign curve_value  = out_val_reg;
    assign used_default = out_dflt_reg;
    assign clamped      = out_clamp_reg;

endmodule

// File: src/piecewise_linear_curve_eval.sv
// A breakpoint write yields no result. An evaluation skips the scan and the divider
// on an empty table or when it clamps; when it interpolates it scans one segment
// per cycle (up to 15) and then runs the 2-bit-per-cycle divider.
// One item is in work at a time; the output register holds a finished result.
// Reset (rst_n, async, active low) clears the count and control; table is undefined.
// ============================================================================
// piecewise_linear_curve_eval
// Clamped piecewise-linear lookup over a table of Q15.16 breakpoints.
// ============================================================================
module piecewise_linear_curve_eval
(
    input  logic                                clk,
    input  logic                                rst_n,

    // Count of valid breakpoints
    input  logic                                cfg_wr_en,
    input  logic [pwlc_pkg::CFG_W-1:0]          cfg_wr_data,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [3:0] point_index, [19:4] point_level, [51:20] point_value,
    // [67:52] query_level, [71:68] zero
    input  logic [pwlc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] command
    input  logic [pwlc_pkg::IN_USER_W-1:0]      s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] curve_value
    output logic [pwlc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] used_default, [1] clamped
    output logic [pwlc_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import pwlc_pkg::*;

    localparam int LEVEL_LSB = SLOT_W;
    localparam int VALUE_LSB = LEVEL_LSB + LEVEL_W;
    localparam int QUERY_LSB = VALUE_LSB + VALUE_W;

    ctl_cmd_t                  cmd;
    dp_status_t                st;
    cmd_t                      s_cmd;
    logic [SLOT_W-1:0]         point_index;
    logic signed [LEVEL_W-1:0] point_level;
    logic signed [VALUE_W-1:0] point_value;
    logic signed [LEVEL_W-1:0] query_level;
    logic                      used_default;
    logic                      clamped;

    // Unpack the incoming transfer
    assign s_cmd       = cmd_t'(s_axis_tuser[0]);
    assign point_index = s_axis_tdata[LEVEL_LSB-1:0];
    assign point_level = s_axis_tdata[VALUE_LSB-1:LEVEL_LSB];
    assign point_value = s_axis_tdata[QUERY_LSB-1:VALUE_LSB];
    assign query_level = s_axis_tdata[QUERY_LSB+LEVEL_W-1:QUERY_LSB];

    // Sequencer: takes one item in idle, walks the table, drives the divider
    pwlc_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_cmd   (s_cmd),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .st      (st),
        .cmd     (cmd)
    );

    // Table, compares, multiplier, divider and the output register
    pwlc_dpath u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .point_index  (point_index),
        .point_level  (point_level),
        .point_value  (point_value),
        .query_level  (query_level),
        .cmd          (cmd),
        .st           (st),
        .curve_value  (m_axis_tdata),
        .used_default (used_default),
        .clamped      (clamped)
    );

    // Pack the result flags
    assign m_axis_tuser = {clamped, used_default};

endmodule

// File: src/pwlc_checker.sv
// ============================================================================
// pwlc_checker
// Port-level checks for the curve evaluator, bound to the top level.
// ============================================================================
module pwlc_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pwlc_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [pwlc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic [pwlc_pkg::IN_USER_W-1:0]      s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [pwlc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic [pwlc_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import pwlc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Default answer is exactly 1.0 and never flagged as clamped
    a_default: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata == ONE_Q16) && !m_axis_tuser[1])
        else $error("default result malformed");

    // A write transfer never raises a result
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_WRITE) |=>
            !$rose(m_axis_tvalid))
        else $error("result after write transfer");

    // An evaluate transfer deasserts the input ready right after it is taken
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_EVAL) |=>
            !s_axis_tready)
        else $error("input taken while evaluating");

endmodule

bind piecewise_linear_curve_eval pwlc_checker u_pwlc_checker (.*);
